@@ rtl/rpid_pkg.sv @@
// Package for the RC PPM/PWM input decoder: field widths, register codes,
// item and result structs and the timer wrap rule. No dependencies.
package rpid_pkg;

  localparam int NumChannelsDef = 8;
  localparam int TsW            = 16;
  localparam int ChanW          = 3;
  localparam int CfgIdxW        = 3;
  localparam int GoodChans      = 4;

  localparam logic [TsW-1:0] WidthPreset  = 16'd1500;
  localparam logic [TsW-1:0] PulseMinRst  = 16'd750;
  localparam logic [TsW-1:0] PulseMaxRst  = 16'd2250;
  localparam logic [TsW-1:0] GoodThrRst   = 16'd985;
  localparam logic [TsW-1:0] SyncGapRst   = 16'd4000;
  localparam logic [GoodChans-1:0] FullMask = 4'hF;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgPpmMode  = 3'd0,
    CfgPulseMin = 3'd1,
    CfgPulseMax = 3'd2,
    CfgGoodThr  = 3'd3,
    CfgSyncGap  = 3'd4
  } cfg_idx_e;

  // Item request codes.
  typedef enum logic {
    ReqEdge = 1'b0,
    ReqRead = 1'b1
  } req_type_e;

  // Register set; pulse_lo and pulse_hi bound the valid PPM interval window.
  typedef struct packed {
    logic           ppm_mode;
    logic [TsW-1:0] pulse_lo;
    logic [TsW-1:0] pulse_hi;
    logic [TsW-1:0] good_threshold;
    logic [TsW-1:0] sync_gap;
  } cfg_t;

  typedef struct packed {
    logic             req_type;
    logic [ChanW-1:0] chan_index;
    logic [TsW-1:0]   timestamp;
  } req_t;

  typedef struct packed {
    logic [TsW-1:0]   read_width;
    logic             width_stored;
    logic [ChanW-1:0] stored_channel;
    logic [TsW-1:0]   stored_width;
    logic             frame_sync;
    logic             failsafe_ping;
    logic             rc_active;
    logic             first_four_good;
  } rsp_t;

  // Interval between two timer stamps. When the later stamp is not greater,
  // the established rule subtracts one more tick, so equal stamps give all ones.
  function automatic logic [TsW-1:0] wrap_diff(input logic [TsW-1:0] earlier,
                                               input logic [TsW-1:0] later);
    logic [TsW-1:0] diff;
    diff = later - earlier;
    if (later > earlier) begin
      return diff;
    end
    return diff - 16'd1;
  endfunction

endpackage

@@ rtl/rpid_stream_if.sv @@
// Valid/ready stream channel for the RC input decoder.
// The payload type is chosen per instance; no package dependency.
interface rpid_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/rpid_core.sv @@
// Decoder state and single-pass item logic of the RC input decoder.
// Depends on rpid_pkg.
module rpid_core import rpid_pkg::*; #(
  parameter int NumChannels = NumChannelsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  req_t req_i,
  input  cfg_t cfg_i,
  output rsp_t rsp_o
);

  localparam int CntW = $clog2(NumChannels + 1);
  localparam int IdxW = $clog2(NumChannels);

  logic [TsW-1:0]         width_q [NumChannels];
  logic [TsW-1:0]         rise_q  [NumChannels];
  logic [NumChannels-1:0] phase_q, phase_d;
  logic [TsW-1:0]         curr_q, curr_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [GoodChans-1:0]   mask_q, mask_d;
  logic                   active_q, active_d;

  logic                   wr_en;
  logic [IdxW-1:0]        wr_idx;
  logic [TsW-1:0]         wr_val;
  logic                   rise_en;

  logic                   chan_ok;
  logic [IdxW-1:0]        ch_idx;
  logic [IdxW-1:0]        cnt_idx;
  logic                   cnt_below;
  logic [TsW-1:0]         ppm_diff;
  logic [TsW-1:0]         pwm_diff;
  logic [GoodChans-1:0]   mask_set;

  assign chan_ok   = 32'(req_i.chan_index) < NumChannels;
  assign ch_idx    = IdxW'(req_i.chan_index);
  assign cnt_idx   = IdxW'(cnt_q);
  assign cnt_below = cnt_q < CntW'(NumChannels);
  assign ppm_diff  = wrap_diff(curr_q, req_i.timestamp);
  assign pwm_diff  = wrap_diff(rise_q[ch_idx], req_i.timestamp);

  // Good-pulse bit for the current PPM channel, only for the first four.
  always_comb begin
    mask_set = mask_q;
    if (cnt_q < CntW'(GoodChans) && ppm_diff > cfg_i.good_threshold) begin
      mask_set[cnt_q[1:0]] = 1'b1;
    end
  end

  // Next state and result for the item at the input.
  always_comb begin
    phase_d  = phase_q;
    curr_d   = curr_q;
    cnt_d    = cnt_q;
    mask_d   = mask_q;
    active_d = active_q;
    wr_en    = 1'b0;
    wr_idx   = ch_idx;
    wr_val   = pwm_diff;
    rise_en  = 1'b0;
    rsp_o    = '0;

    if (req_i.req_type == ReqRead) begin
      if (chan_ok) begin
        rsp_o.read_width = width_q[ch_idx];
      end
    end else if (cfg_i.ppm_mode) begin
      curr_d   = req_i.timestamp;
      active_d = 1'b1;
      if (ppm_diff > cfg_i.sync_gap) begin
        cnt_d            = '0;
        rsp_o.frame_sync = 1'b1;
      end else begin
        if (ppm_diff > cfg_i.pulse_lo && ppm_diff < cfg_i.pulse_hi && cnt_below) begin
          wr_en                = 1'b1;
          wr_idx               = cnt_idx;
          wr_val               = ppm_diff;
          rsp_o.width_stored   = 1'b1;
          rsp_o.stored_channel = ChanW'(cnt_q);
          rsp_o.stored_width   = ppm_diff;
          if (mask_set == FullMask) begin
            mask_d                = '0;
            rsp_o.first_four_good = 1'b1;
          end else begin
            mask_d = mask_set;
          end
        end
        if (cnt_below) begin
          cnt_d = cnt_q + CntW'(1);
        end
        rsp_o.failsafe_ping = 1'b1;
      end
    end else if (chan_ok) begin
      if (!phase_q[ch_idx]) begin
        rise_en         = 1'b1;
        phase_d[ch_idx] = 1'b1;
      end else begin
        wr_en                = 1'b1;
        phase_d[ch_idx]      = 1'b0;
        rsp_o.width_stored   = 1'b1;
        rsp_o.stored_channel = req_i.chan_index;
        rsp_o.stored_width   = pwm_diff;
        rsp_o.failsafe_ping  = 1'b1;
      end
    end
    rsp_o.rc_active = active_d;
  end

  // Control state and the width table, which resets to the preset width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      curr_q   <= '0;
      cnt_q    <= '0;
      mask_q   <= '0;
      active_q <= 1'b0;
      for (int i = 0; i < NumChannels; i++) begin
        width_q[i] <= WidthPreset;
      end
    end else if (fire_i) begin
      phase_q  <= phase_d;
      curr_q   <= curr_d;
      cnt_q    <= cnt_d;
      mask_q   <= mask_d;
      active_q <= active_d;
      if (wr_en) begin
        width_q[wr_idx] <= wr_val;
      end
    end
  end

  // Rise stamps are only read after they were written.
  always_ff @(posedge clk_i) begin
    if (fire_i && rise_en) begin
      rise_q[ch_idx] <= req_i.timestamp;
    end
  end

  // The PPM channel count saturates at the channel count.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= NumChannels)
    else $error("PPM channel count beyond channel count");

  // A completed good mask is cleared in the same step.
  a_mask_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_q != FullMask)
    else $error("good mask left full");

  // Read items leave the decoder state untouched.
  a_read_no_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && req_i.req_type == ReqRead |=>
      $stable(cnt_q) && $stable(mask_q) && $stable(phase_q) && $stable(curr_q))
    else $error("read item changed decoder state");

  // The active flag is sticky.
  a_active_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(active_q))
    else $error("active flag cleared");

  // A good-mask completion only comes with a stored width, never with a sync.
  a_good_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && rsp_o.first_four_good |-> rsp_o.width_stored && !rsp_o.frame_sync)
    else $error("good mask completion without stored width");

endmodule

@@ rtl/rpid_out_reg.sv @@
// Result register of the RC input decoder: holds one result item until the
// receiver takes it and throttles the input side. Depends on rpid_pkg.
module rpid_out_reg import rpid_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  rsp_t          rsp_i,
  output logic          in_ready_o,
  rpid_stream_if.source rsp_if
);

  logic valid_q;
  rsp_t data_q;

  // A new item may enter while the held result leaves in the same cycle.
  assign in_ready_o = !valid_q || rsp_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (fire_i) begin
      valid_q <= 1'b1;
    end else if (rsp_if.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      data_q <= rsp_i;
    end
  end

  assign rsp_if.valid = valid_q;
  assign rsp_if.data  = data_q;

endmodule

@@ rtl/rc_ppm_pwm_input_decoder.sv @@
// Top level of the RC PPM/PWM input decoder: configuration registers, the
// decoder core and the result register. Depends on rpid_pkg, rpid_stream_if,
// rpid_core and rpid_out_reg.
//
// Usage:
//   req_if carries items (req_type, chan_index, timestamp) of type req_t:
//   a capture edge or a read of one stored channel width. rsp_if returns
//   exactly one result item of type rsp_t for each accepted item, in order.
//   The configuration port writes ppm_mode, the two PPM window bounds,
//   good_threshold and sync_gap by index; write only while no item is in
//   flight. Indexes beyond the list are ignored.
//   Latency: the result of an item is valid in the cycle after it is
//   accepted. Throughput: one item per cycle, set by the single pass of
//   compare and subtract logic between the input and the result register.
//   Stall: while a result waits, a new item is still taken if the receiver
//   takes the waiting one in the same cycle; otherwise req_if.ready drops.
//   Reset: all widths read 1500, every PWM channel awaits a rising edge,
//   the PPM count, good mask, last stamp and active flag are cleared and
//   the registers take their default values.
module rc_ppm_pwm_input_decoder import rpid_pkg::*; #(
  parameter int NumChannels = NumChannelsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TsW-1:0]     cfg_wdata_i,
  rpid_stream_if.sink        req_if,
  rpid_stream_if.source      rsp_if
);

  cfg_t cfg_q;
  rsp_t rsp_d;
  logic in_ready;
  logic fire;

  assign req_if.ready = in_ready;
  assign fire         = req_if.valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ppm_mode       <= 1'b0;
      cfg_q.pulse_lo       <= PulseMinRst;
      cfg_q.pulse_hi       <= PulseMaxRst;
      cfg_q.good_threshold <= GoodThrRst;
      cfg_q.sync_gap       <= SyncGapRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPpmMode:  cfg_q.ppm_mode       <= cfg_wdata_i[0];
        CfgPulseMin: cfg_q.pulse_lo       <= cfg_wdata_i;
        CfgPulseMax: cfg_q.pulse_hi       <= cfg_wdata_i;
        CfgGoodThr:  cfg_q.good_threshold <= cfg_wdata_i;
        CfgSyncGap:  cfg_q.sync_gap       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rpid_core #(
    .NumChannels(NumChannels)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .req_i (req_if.data),
    .cfg_i (cfg_q),
    .rsp_o (rsp_d)
  );

  rpid_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .rsp_i     (rsp_d),
    .in_ready_o(in_ready),
    .rsp_if    (rsp_if)
  );

endmodule
